/* hw/rtl/phr_pkg.sv */
`timescale 1ns / 1ps

package phr_pkg;

   // packed colour layout
   localparam int HUE_LSB   = 10;
   localparam int HUE_BITS  = 6;
   localparam int SAT_LSB   = 7;
   localparam int SAT_BITS  = 3;
   localparam int LIGHT_LSB = 0;
   localparam int LIGHT_BITS = 7;

   localparam int CHANNELS  = 3;
   localparam int BYTE_BITS = 8;

   // piece of the hue-to-channel curve that a channel falls on
   typedef enum logic [1:0] {
      RGN_RISE = 2'd0,
      RGN_HIGH = 2'd1,
      RGN_FALL = 2'd2,
      RGN_LOW  = 2'd3
   } region_type;

endpackage

/* hw/rtl/packed_hsl_to_rgb.sv */
// packed_hsl_to_rgb: packed 16-bit hsl colour in, 8-bit red, green and blue out
// each accepted req beat moves through stages st1 to st5 and leaves as its rsp beat
// throughput: one beat per cycle while not stalled, five register stages advance together
// a stalled rsp beat freezes every stage, so req_ready is low only while an rsp beat is stalled
// reset (synchronous, active high) clears the stage valid bits only
`timescale 1ns / 1ps

module packed_hsl_to_rgb
   import phr_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_packed_color,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue
);

   // unit values need one integer bit on top of the fraction
   localparam int W  = FRAC_BITS + 1;
   localparam int FW = W + 1;          // scale factor width
   localparam int SW = W + 2;          // signed working width
   localparam int XW = W + BYTE_BITS + 1;

   localparam longint ONE_L   = longint'(1) << FRAC_BITS;
   localparam longint HALF_L  = ONE_L / 2;
   localparam longint THIRD_L = (ONE_L + 1) / 3;
   localparam longint SIXTH_L = (ONE_L + 3) / 6;
   localparam longint TT_L    = (2 * ONE_L + 1) / 3;
   localparam longint MAXB_L  = 255 * ONE_L;

   localparam logic signed [SW-1:0] ONE_S   = SW'(ONE_L);
   localparam logic signed [SW-1:0] HALF_S  = SW'(HALF_L);
   localparam logic signed [SW-1:0] THIRD_S = SW'(THIRD_L);
   localparam logic signed [SW-1:0] SIXTH_S = SW'(SIXTH_L);
   localparam logic signed [SW-1:0] TT_S    = SW'(TT_L);
   localparam logic [XW-1:0]        MAXB_X  = XW'(MAXB_L);

   // ------------------------------------------------------------------
   // constant tables for s = sat/7 and l = light/127, rounded to nearest
   // ------------------------------------------------------------------
   logic [W-1:0] sat_lut   [1 << SAT_BITS];
   logic [W-1:0] light_lut [1 << LIGHT_BITS];

   for (genvar i = 0; i < (1 << SAT_BITS); i++) begin : g_sat
      localparam longint SV = ((longint'(i) << FRAC_BITS) + 3) / 7;
      assign sat_lut[i] = SV[W-1:0];
   end

   for (genvar i = 0; i < (1 << LIGHT_BITS); i++) begin : g_light
      localparam longint LV = ((longint'(i) << FRAC_BITS) + 63) / 127;
      assign light_lut[i] = LV[W-1:0];
   end

   // whole pipe moves together; a waiting rsp beat holds everything
   logic advance;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // ------------------------------------------------------------------
   // stage 1: field decode and table lookup
   // ------------------------------------------------------------------
   logic               st1_valid_ff;
   logic               st1_grey_ff,  st1_grey_in;
   logic [W-1:0]       st1_h_ff,     st1_h_in;
   logic [W-1:0]       st1_s_ff,     st1_s_in;
   logic [W-1:0]       st1_l_ff,     st1_l_in;

   logic [HUE_BITS-1:0]   hue_field;
   logic [SAT_BITS-1:0]   sat_field;
   logic [LIGHT_BITS-1:0] light_field;

   always_comb begin
      hue_field   = req_packed_color[HUE_LSB +: HUE_BITS];
      sat_field   = req_packed_color[SAT_LSB +: SAT_BITS];
      light_field = req_packed_color[LIGHT_LSB +: LIGHT_BITS];
      st1_grey_in = (sat_field == '0);
      // hue/64 is exact: just a shift into the fraction
      st1_h_in    = W'(hue_field) << (FRAC_BITS - HUE_BITS);
      st1_s_in    = sat_lut[sat_field];
      st1_l_in    = light_lut[light_field];
   end

   // ------------------------------------------------------------------
   // stage 2: l * s
   // ------------------------------------------------------------------
   logic               st2_valid_ff;
   logic               st2_grey_ff;
   logic [W-1:0]       st2_h_ff;
   logic [W-1:0]       st2_s_ff;
   logic [W-1:0]       st2_l_ff;
   logic [W-1:0]       st2_ls_ff, st2_ls_in;
   logic [2*W-1:0]     ls_full;

   always_comb begin
      ls_full   = st1_l_ff * st1_s_ff;
      st2_ls_in = ls_full[FRAC_BITS +: W];
   end

   // ------------------------------------------------------------------
   // stage 3: p, q, span and per channel curve region and slope factor
   // ------------------------------------------------------------------
   logic               st3_valid_ff;
   logic               st3_grey_ff;
   logic [W-1:0]       st3_l_ff;
   logic [W-1:0]       st3_p_ff,    st3_p_in;
   logic [W-1:0]       st3_q_ff,    st3_q_in;
   logic [W-1:0]       st3_span_ff, st3_span_in;
   region_type         st3_rgn_ff [CHANNELS];
   region_type         st3_rgn_in [CHANNELS];
   logic [FW-1:0]      st3_fac_ff [CHANNELS];
   logic [FW-1:0]      st3_fac_in [CHANNELS];

   logic signed [SW-1:0] l_x, s_x, ls_x, h_x;
   logic signed [SW-1:0] q_raw, q_cl, p_raw, p_cl, span_raw;
   logic signed [SW-1:0] t_raw [CHANNELS];

   // wrap hue offset into the unit range, pick the curve piece and
   // the factor that multiplies the span
   function automatic void curve_piece(input  logic signed [SW-1:0] t_arg,
                                       output region_type           rgn,
                                       output logic [FW-1:0]        fac);
      logic signed [SW-1:0]   t;
      logic signed [SW+2:0]   six;
      t   = t_arg;
      six = '0;
      if (t < 0) begin
         t = t + ONE_S;
      end
      if (t > ONE_S) begin
         t = t - ONE_S;
      end
      if (t < SIXTH_S) begin
         rgn = RGN_RISE;
         six = ((SW+3)'(t) <<< 2) + ((SW+3)'(t) <<< 1);
      end else if (t < HALF_S) begin
         rgn = RGN_HIGH;
      end else if (t < TT_S) begin
         rgn = RGN_FALL;
         six = ((SW+3)'(TT_S - t) <<< 2) + ((SW+3)'(TT_S - t) <<< 1);
      end else begin
         rgn = RGN_LOW;
      end
      fac = six[FW-1:0];
   endfunction

   always_comb begin
      l_x  = SW'(st2_l_ff);
      s_x  = SW'(st2_s_ff);
      ls_x = SW'(st2_ls_ff);
      h_x  = SW'(st2_h_ff);

      q_raw = (l_x < HALF_S) ? (l_x + ls_x) : (l_x + s_x - ls_x);
      q_cl  = (q_raw > ONE_S) ? ONE_S : ((q_raw < 0) ? '0 : q_raw);
      p_raw = (l_x <<< 1) - q_cl;
      p_cl  = (p_raw > ONE_S) ? ONE_S : ((p_raw < 0) ? '0 : p_raw);
      span_raw = q_cl - p_cl;

      st3_q_in    = q_cl[W-1:0];
      st3_p_in    = p_cl[W-1:0];
      st3_span_in = (span_raw < 0) ? '0 : span_raw[W-1:0];

      // red at +1/3, green at 0, blue at -1/3
      t_raw[0] = h_x + THIRD_S;
      t_raw[1] = h_x;
      t_raw[2] = h_x - THIRD_S;
      for (int c = 0; c < CHANNELS; c++) begin
         curve_piece(t_raw[c], st3_rgn_in[c], st3_fac_in[c]);
      end
   end

   // ------------------------------------------------------------------
   // stage 4: span * factor, one multiplier per channel
   // ------------------------------------------------------------------
   logic               st4_valid_ff;
   logic               st4_grey_ff;
   logic [W-1:0]       st4_l_ff;
   logic [W-1:0]       st4_p_ff;
   logic [W-1:0]       st4_q_ff;
   region_type         st4_rgn_ff  [CHANNELS];
   logic [FW-1:0]      st4_prod_ff [CHANNELS];
   logic [FW-1:0]      st4_prod_in [CHANNELS];
   logic [W+FW-1:0]    prod_full   [CHANNELS];

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         prod_full[c]   = st3_span_ff * st3_fac_ff[c];
         st4_prod_in[c] = prod_full[c][FRAC_BITS +: FW];
      end
   end

   // ------------------------------------------------------------------
   // stage 5: channel value, clamp, scale to a byte
   // ------------------------------------------------------------------
   logic               st5_valid_ff;
   logic               st5_grey_ff;
   logic [BYTE_BITS-1:0] st5_byte_ff [CHANNELS];
   logic [BYTE_BITS-1:0] st5_byte_in [CHANNELS];

   function automatic logic [BYTE_BITS-1:0] to_byte(input logic [W:0] v_arg);
      logic [W:0]    v;
      logic [XW-1:0] x;
      v = (v_arg > (W+1)'(ONE_L)) ? (W+1)'(ONE_L) : v_arg;
      // v * 255 as v * 256 - v
      x = (XW'(v) << BYTE_BITS) - XW'(v);
      if (x > MAXB_X) begin
         x = MAXB_X;
      end
      return x[FRAC_BITS +: BYTE_BITS];
   endfunction

   logic [W:0] chan_v [CHANNELS];

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         case (st4_rgn_ff[c]) inside
            RGN_RISE, RGN_FALL: chan_v[c] = (W+1)'(st4_p_ff) + (W+1)'(st4_prod_ff[c]);
            RGN_HIGH:           chan_v[c] = (W+1)'(st4_q_ff);
            default:            chan_v[c] = (W+1)'(st4_p_ff);
         endcase
         // zero saturation: every channel is the lightness itself
         if (st4_grey_ff) begin
            chan_v[c] = (W+1)'(st4_l_ff);
         end
         st5_byte_in[c] = to_byte(chan_v[c]);
      end
   end

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         st1_valid_ff <= 1'b0;
         st2_valid_ff <= 1'b0;
         st3_valid_ff <= 1'b0;
         st4_valid_ff <= 1'b0;
         st5_valid_ff <= 1'b0;
      end else if (advance) begin
         st1_valid_ff <= req_valid;
         st2_valid_ff <= st1_valid_ff;
         st3_valid_ff <= st2_valid_ff;
         st4_valid_ff <= st3_valid_ff;
         st5_valid_ff <= st4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st1_grey_ff <= st1_grey_in;
         st1_h_ff    <= st1_h_in;
         st1_s_ff    <= st1_s_in;
         st1_l_ff    <= st1_l_in;

         st2_grey_ff <= st1_grey_ff;
         st2_h_ff    <= st1_h_ff;
         st2_s_ff    <= st1_s_ff;
         st2_l_ff    <= st1_l_ff;
         st2_ls_ff   <= st2_ls_in;

         st3_grey_ff <= st2_grey_ff;
         st3_l_ff    <= st2_l_ff;
         st3_p_ff    <= st3_p_in;
         st3_q_ff    <= st3_q_in;
         st3_span_ff <= st3_span_in;

         st4_grey_ff <= st3_grey_ff;
         st4_l_ff    <= st3_l_ff;
         st4_p_ff    <= st3_p_ff;
         st4_q_ff    <= st3_q_ff;

         st5_grey_ff <= st4_grey_ff;

         for (int c = 0; c < CHANNELS; c++) begin
            st3_rgn_ff[c]  <= st3_rgn_in[c];
            st3_fac_ff[c]  <= st3_fac_in[c];
            st4_rgn_ff[c]  <= st3_rgn_ff[c];
            st4_prod_ff[c] <= st4_prod_in[c];
            st5_byte_ff[c] <= st5_byte_in[c];
         end
      end
   end

   assign rsp_valid = st5_valid_ff;
   assign rsp_red   = st5_byte_ff[0];
   assign rsp_green = st5_byte_ff[1];
   assign rsp_blue  = st5_byte_ff[2];

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("req beat taken while rsp beat stalled");

   a_p_below_q: assert property (@(posedge clock) disable iff (reset)
      st3_valid_ff |-> (st3_p_ff <= st3_q_ff))
      else $error("p above q");

   a_grey_equal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && st5_grey_ff) |-> ((rsp_red == rsp_green) && (rsp_green == rsp_blue)))
      else $error("grey beat with unequal channels");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid straight after reset");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top
   import phr_pkg::*;
();

   localparam int     FRAC_BITS   = 16;
   localparam longint UNIT        = longint'(1) << FRAC_BITS;
   localparam int     RESET_CYCLES = 9;
   localparam int     RANDOM_COLOURS = 1700;
   // the result count at which the receiver takes a long break
   localparam int     HOLD_AT_FIRST  = 400;
   localparam int     HOLD_AT_SECOND = 1200;
   localparam int     LONG_HOLD      = 150;
   // pipeline is five stages deep, so this is plenty to flush it
   localparam int     SETTLE_CYCLES  = 20;
   localparam int     CYCLE_LIMIT    = 400000;
   localparam int     REPORT_LIMIT   = 10;

   // receiver back-pressure styles
   typedef enum int {
      STALL_NONE,
      STALL_COIN,
      STALL_SPARSE,
      STALL_MASK
   } stall_mode_type;

   typedef struct {
      bit          wait_idle;   // hold this beat back until the pipe is empty
      logic [15:0] colour;
   } colour_beat_type;

   typedef struct {
      logic [15:0] colour;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } rgb_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_packed_color = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;

   colour_beat_type colour_stim[$];   // colours still to be offered
   rgb_beat_type    rgb_expect[$];    // predicted rsp beats, oldest first
   colour_beat_type next_colour;
   rgb_beat_type    want;

   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;

   // sender burst state
   int unsigned burst_left;
   int unsigned gap_left;

   // receiver stall state
   stall_mode_type ready_mode;
   int unsigned mode_left;
   int unsigned hold_left;
   int unsigned beats_seen;
   logic [7:0]  ready_mask;
   logic [2:0]  mask_pos;

   packed_hsl_to_rgb #(
      .FRAC_BITS(FRAC_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_packed_color(req_packed_color),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_red         (rsp_red),
      .rsp_green       (rsp_green),
      .rsp_blue        (rsp_blue)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------
   // fixed-point colour predictor
   // ------------------------------------------------------------------

   function automatic longint unit_clamp(longint v);
      if (v < 0) return 0;
      if (v > UNIT) return UNIT;
      return v;
   endfunction

   // scale a unit value to a byte, clamped then truncated
   function automatic logic [7:0] unit_to_byte(longint v);
      longint scaled;
      scaled = unit_clamp(v) * 255;
      if (scaled > 255 * UNIT) scaled = 255 * UNIT;
      return 8'(scaled >> FRAC_BITS);
   endfunction

   // hue-to-channel curve: rise, plateau at q, fall, floor at p
   function automatic longint curve_level(longint p, longint q, longint t);
      longint sixth;
      longint half;
      longint two_thirds;
      longint span;
      longint tw;
      sixth      = (UNIT + 3) / 6;
      half       = UNIT / 2;
      two_thirds = (2 * UNIT + 1) / 3;
      span       = q - p;
      if (span < 0) span = 0;
      tw = t;
      if (tw < 0) tw += UNIT;
      if (tw > UNIT) tw -= UNIT;
      if (tw < 0) tw = 0;
      if (tw < sixth) return unit_clamp(p + ((span * 6 * tw) >> FRAC_BITS));
      if (tw < half) return unit_clamp(q);
      if (tw < two_thirds)
         return unit_clamp(p + ((span * (two_thirds - tw) * 6) >> FRAC_BITS));
      return unit_clamp(p);
   endfunction

   function automatic rgb_beat_type hsl_to_rgb_predict(logic [15:0] colour);
      longint    hue;
      longint    sat;
      longint    light;
      longint    h;
      longint    s;
      longint    l;
      longint    third;
      longint    ls;
      longint    q;
      longint    p;
      rgb_beat_type res;
      hue   = longint'(colour[HUE_LSB +: HUE_BITS]);
      sat   = longint'(colour[SAT_LSB +: SAT_BITS]);
      light = longint'(colour[LIGHT_LSB +: LIGHT_BITS]);
      h     = hue << (FRAC_BITS - HUE_BITS);
      // saturation and lightness scaled with round to nearest
      s     = (sat * UNIT + 3) / 7;
      l     = (light * UNIT + 63) / 127;
      res.colour = colour;
      if (sat == 0) begin
         // grey: every channel follows lightness
         res.red   = unit_to_byte(l);
         res.green = res.red;
         res.blue  = res.red;
         return res;
      end
      third = (UNIT + 1) / 3;
      ls    = (l * s) >> FRAC_BITS;
      q     = (l < UNIT / 2) ? (l + ls) : (l + s - ls);
      q     = unit_clamp(q);
      p     = unit_clamp(2 * l - q);
      res.red   = unit_to_byte(curve_level(p, q, h + third));
      res.green = unit_to_byte(curve_level(p, q, h));
      res.blue  = unit_to_byte(curve_level(p, q, h - third));
      return res;
   endfunction

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------

   task automatic add_colour(int hue, int sat, int light, bit wait_idle);
      colour_beat_type b;
      b.wait_idle = wait_idle;
      b.colour    = {6'(hue), 3'(sat), 7'(light)};
      colour_stim.push_back(b);
   endtask

   // hue positions either side of each corner of the channel curve
   int curve_hues[11] = '{0, 10, 11, 21, 22, 32, 42, 43, 53, 54, 63};

   initial begin
      // extremes: black and white, grey and fully saturated
      add_colour(0, 0, 0, 1'b0);
      add_colour(0, 0, 127, 1'b0);
      add_colour(63, 7, 127, 1'b0);
      add_colour(63, 7, 0, 1'b0);
      add_colour(40, 0, 64, 1'b0);
      // either side of half lightness, where q changes its formula
      add_colour(0, 7, 63, 1'b0);
      add_colour(0, 7, 64, 1'b0);
      // walk the hue across every piece of the curve
      foreach (curve_hues[i]) add_colour(curve_hues[i], 7, 64, 1'b0);
      // weak saturation near the lightness ends, then two mid saturations
      add_colour(5, 1, 1, 1'b0);
      add_colour(50, 1, 126, 1'b0);
      add_colour(21, 3, 100, 1'b0);
      add_colour(33, 4, 20, 1'b0);

      // random colours; the first and a middle one wait for an empty pipe
      for (int i = 0; i < RANDOM_COLOURS; i++) begin
         colour_beat_type b;
         b.wait_idle = (i == 0) || (i == RANDOM_COLOURS / 2);
         b.colour    = 16'($urandom_range(0, 16'hFFFF));
         colour_stim.push_back(b);
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (colour_stim.size() != 0 || req_valid || rgb_expect.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0 && rgb_expect.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // req driver: bursts of beats with random gaps between them
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         req_valid        <= 1'b0;
         req_packed_color <= '0;
         burst_left = 8;
         gap_left   = 0;
      end else if (!req_valid || req_ready) begin
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (colour_stim.size() == 0 ||
                      (colour_stim[0].wait_idle && rgb_expect.size() != 0)) begin
            req_valid <= 1'b0;
         end else begin
            next_colour = colour_stim.pop_front();
            // the beat is held until taken, so predict it now
            rgb_expect.push_back(hsl_to_rgb_predict(next_colour.colour));
            req_valid        <= 1'b1;
            req_packed_color <= next_colour.colour;
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               // mostly short gaps, now and then a long one or none at all
               if ($urandom_range(0, 7) == 0) gap_left = $urandom_range(10, 30);
               else gap_left = $urandom_range(0, 4);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // rsp receiver: changing stall style plus two long hold-offs
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_mode = STALL_NONE;
         mode_left  = 0;
         hold_left  = 0;
         beats_seen = 0;
         ready_mask = 8'hFF;
         mask_pos   = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            beats_seen++;
            if (beats_seen == HOLD_AT_FIRST || beats_seen == HOLD_AT_SECOND)
               hold_left = LONG_HOLD;
         end
         if (mode_left == 0) begin
            ready_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(16, 96);
            ready_mask = 8'($urandom);
            if (ready_mask == '0) ready_mask = 8'h01;
         end else begin
            mode_left--;
         end
         mask_pos++;
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (ready_mode)
               STALL_NONE:   rsp_ready <= 1'b1;
               STALL_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
               STALL_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
               default:      rsp_ready <= ready_mask[mask_pos];
            endcase
         end
      end
   end

   // ------------------------------------------------------------------
   // rsp monitor: each beat against the oldest prediction
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (rgb_expect.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected rsp beat: r %0d g %0d b %0d",
                        rsp_red, rsp_green, rsp_blue);
         end else begin
            want = rgb_expect.pop_front();
            if (rsp_red !== want.red || rsp_green !== want.green ||
                rsp_blue !== want.blue) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("colour %h: expected r %0d g %0d b %0d, got r %0d g %0d b %0d",
                           want.colour, want.red, want.green, want.blue,
                           rsp_red, rsp_green, rsp_blue);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

endmodule
